// File: rtl/mspf_pkg.sv
// Package for the matrix saddle point finder: defaults, codes, state and result types.
`default_nettype none
package mspf_pkg;

  localparam int unsigned MaxRowsDef   = 16;
  localparam int unsigned MaxColsDef   = 16;
  localparam int unsigned DataWidthDef = 16;

  // Width of the dimension registers and of the coordinate fields
  localparam int unsigned DimW    = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegRowCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegColCount = 2'd1;

  localparam logic [DimW-1:0] DimResetVal = 5'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW,
    ST_COL,
    ST_EMIT,
    ST_FINAL
  } st_e;

  typedef struct packed {
    logic [DimW-1:0] row_number;
    logic [DimW-1:0] col_number;
    logic            kind;
    logic            found;
    logic            last_result;
  } res_tag_t;

endpackage
`default_nettype wire

// File: rtl/matrix_saddle_point_finder_unit.sv
// Saddle point search over a row-major matrix held in an on-chip memory.
// Loading: elements are written to memory in arrival order; a pending register
//   write holds them off, and none are taken while a search is running.
// Search: limited by the single memory read port and one shared signed comparator,
//   and can be held while the result output stalls; the next matrix loads after it closes.
// Reset: dimensions 4x4, load restarts at element 0, no result pending;
//   memory contents are undefined until loaded, no clearing pass.
`default_nettype none
module matrix_saddle_point_finder_unit
  import mspf_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = MaxRowsDef,
  parameter int unsigned MAX_COLS   = MaxColsDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // element channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0] element_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [DimW-1:0]                   row_number_o,
  output logic [DimW-1:0]                   col_number_o,
  output logic signed [DATA_WIDTH-1:0]      point_value_o,
  output logic                              kind_o,
  output logic                              found_o,
  output logic                              last_result_o,
  // configuration write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]           cfg_index_i,
  input  wire logic [DimW-1:0]              cfg_data_i
);

  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned IW    = (RW > CW) ? RW : CW;
  localparam int unsigned Cells = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned EW    = 7;

  localparam logic [EW-1:0] MaxRowsE = EW'(MAX_ROWS);
  localparam logic [EW-1:0] MaxColsE = EW'(MAX_COLS);
  localparam logic [AW-1:0] ColsA    = AW'(MAX_COLS);

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * ColsA + AW'(c));
  endfunction

  st_e state_q, state_d;

  logic [DimW-1:0] row_count_q, row_count_d;
  logic [DimW-1:0] col_count_q, col_count_d;
  logic [RW-1:0]   ld_row_q, ld_row_d;
  logic [CW-1:0]   ld_col_q, ld_col_d;

  logic            pass_q, pass_d;
  logic [RW-1:0]   row_q, row_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            issue_q, issue_d;
  logic            rd_vld_q, rd_vld_d;
  logic            rd_last_q, rd_last_d;
  logic [CW-1:0]   rd_col_q, rd_col_d;
  logic            ok_q, ok_d;

  logic signed [DATA_WIDTH-1:0] best_q, best_d;
  logic [CW-1:0]                best_col_q, best_col_d;
  logic signed [DATA_WIDTH-1:0] rd_data_q;

  logic                         pend_vld_q, pend_vld_d;
  res_tag_t                     pend_tag_q, pend_tag_d;
  logic signed [DATA_WIDTH-1:0] pend_val_q, pend_val_d;

  logic                         out_vld_q, out_vld_d;
  res_tag_t                     out_tag_q, out_tag_d;
  logic signed [DATA_WIDTH-1:0] out_val_q, out_val_d;

  logic signed [DATA_WIDTH-1:0] mem [Cells];

  logic [EW-1:0] rows_e, cols_e;
  logic [RW-1:0] rows_m1;
  logic [CW-1:0] cols_m1;
  logic          in_acc, cfg_wr, out_free, out_push;
  logic          mem_we, issue;
  logic [AW-1:0] waddr, raddr;
  logic          row_done, rows_end, emit_go;
  logic signed [DATA_WIDTH-1:0] cmp_x, cmp_y;
  logic          cmp_gt;

  // Effective dimensions: zero acts as one, large values clamp to the maximum
  always_comb begin
    rows_e = EW'(row_count_q);
    cols_e = EW'(col_count_q);
    if (rows_e == '0) rows_e = EW'(1);
    else if (rows_e > MaxRowsE) rows_e = MaxRowsE;
    if (cols_e == '0) cols_e = EW'(1);
    else if (cols_e > MaxColsE) cols_e = MaxColsE;
    rows_m1 = RW'(rows_e - EW'(1));
    cols_m1 = CW'(cols_e - EW'(1));
  end

  // a pending register write holds off the element request
  assign in_stall_o  = (state_q != ST_LOAD) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_vld_q || !out_stall_i;

  assign row_done = rd_vld_q && rd_last_q;
  assign rows_end = (row_q == rows_m1);
  assign emit_go  = !ok_q || !pend_vld_q || out_free;

  // Shared comparator: row scan looks for a better candidate, column scan for a violation
  always_comb begin
    if ((state_q == ST_ROW) ^ pass_q) begin
      cmp_x = best_q;
      cmp_y = rd_data_q;
    end else begin
      cmp_x = rd_data_q;
      cmp_y = best_q;
    end
    cmp_gt = cmp_x > cmp_y;
  end

  assign waddr = cell_addr(ld_row_q, ld_col_q);
  assign raddr = (state_q == ST_ROW) ? cell_addr(row_q, idx_q[CW-1:0])
                                     : cell_addr(idx_q[RW-1:0], best_col_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (!cfg_wr && in_acc && ld_col_q == cols_m1 && ld_row_q == rows_m1) state_d = ST_ROW;
      end
      ST_ROW:   if (row_done) state_d = ST_COL;
      ST_COL:   if (row_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_d = (rows_end && pass_q) ? ST_FINAL : ST_ROW;
      end
      ST_FINAL: if (out_free) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // Datapath and sequencer outputs
  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    ld_row_d    = ld_row_q;
    ld_col_d    = ld_col_q;
    pass_d      = pass_q;
    row_d       = row_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    ok_d        = ok_q;
    best_d      = best_q;
    best_col_d  = best_col_q;
    pend_vld_d  = pend_vld_q;
    pend_tag_d  = pend_tag_q;
    pend_val_d  = pend_val_q;
    out_tag_d   = out_tag_q;
    out_val_d   = out_val_q;
    mem_we      = 1'b0;
    issue       = 1'b0;
    out_push    = 1'b0;
    rd_col_d    = idx_q[CW-1:0];
    rd_last_d   = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (cfg_wr) begin
          if (cfg_index_i == RegRowCount) begin
            row_count_d = cfg_data_i;
            ld_row_d    = '0;
            ld_col_d    = '0;
          end else if (cfg_index_i == RegColCount) begin
            col_count_d = cfg_data_i;
            ld_row_d    = '0;
            ld_col_d    = '0;
          end
        end else if (in_acc) begin
          mem_we = 1'b1;
          if (ld_col_q == cols_m1) begin
            ld_col_d = '0;
            if (ld_row_q == rows_m1) begin
              ld_row_d = '0;
              pass_d   = 1'b0;
              row_d    = '0;
              idx_d    = '0;
              issue_d  = 1'b1;
            end else begin
              ld_row_d = RW'(ld_row_q + 1'b1);
            end
          end else begin
            ld_col_d = CW'(ld_col_q + 1'b1);
          end
        end
      end
      ST_ROW: begin
        if (issue_q) begin
          issue     = 1'b1;
          rd_last_d = (idx_q == IW'(cols_m1));
          idx_d     = IW'(idx_q + 1'b1);
          if (rd_last_d) issue_d = 1'b0;
        end
        if (rd_vld_q) begin
          // first element seeds the candidate; ties keep the earlier column
          if (rd_col_q == '0 || cmp_gt) begin
            best_d     = rd_data_q;
            best_col_d = rd_col_q;
          end
          if (rd_last_q) begin
            idx_d   = '0;
            issue_d = 1'b1;
            ok_d    = 1'b1;
          end
        end
      end
      ST_COL: begin
        if (issue_q) begin
          issue     = 1'b1;
          rd_last_d = (idx_q == IW'(rows_m1));
          idx_d     = IW'(idx_q + 1'b1);
          if (rd_last_d) issue_d = 1'b0;
        end
        if (rd_vld_q && cmp_gt) ok_d = 1'b0;
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (ok_q) begin
            if (pend_vld_q) begin
              out_push  = 1'b1;
              out_tag_d = pend_tag_q;
              out_val_d = pend_val_q;
            end
            pend_vld_d             = 1'b1;
            pend_tag_d.row_number  = DimW'(row_q) + DimW'(1);
            pend_tag_d.col_number  = DimW'(best_col_q) + DimW'(1);
            pend_tag_d.kind        = pass_q;
            pend_tag_d.found       = 1'b1;
            pend_tag_d.last_result = 1'b0;
            pend_val_d             = best_q;
          end
          if (rows_end) begin
            row_d  = '0;
            pass_d = 1'b1;
          end else begin
            row_d = RW'(row_q + 1'b1);
          end
          idx_d   = '0;
          issue_d = !(rows_end && pass_q);
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_push = 1'b1;
          if (pend_vld_q) begin
            out_tag_d = pend_tag_q;
            out_val_d = pend_val_q;
          end else begin
            out_tag_d = '0;
            out_val_d = '0;
          end
          out_tag_d.last_result = 1'b1;
          pend_vld_d            = 1'b0;
        end
      end
      default: ;
    endcase

    rd_vld_d = issue;
  end

  always_comb begin
    if (out_push) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      row_count_q <= DimResetVal;
      col_count_q <= DimResetVal;
      ld_row_q    <= '0;
      ld_col_q    <= '0;
      pass_q      <= 1'b0;
      row_q       <= '0;
      idx_q       <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      ok_q        <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
      ld_row_q    <= ld_row_d;
      ld_col_q    <= ld_col_d;
      pass_q      <= pass_d;
      row_q       <= row_d;
      idx_q       <= idx_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      ok_q        <= ok_d;
      pend_vld_q  <= pend_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_col_q <= best_col_d;
    rd_col_q   <= rd_col_d;
    pend_tag_q <= pend_tag_d;
    pend_val_q <= pend_val_d;
    out_tag_q  <= out_tag_d;
    out_val_q  <= out_val_d;
  end

  // Matrix memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= element_i;
    if (issue) rd_data_q <= mem[raddr];
  end

  assign out_valid_o   = out_vld_q;
  assign row_number_o  = out_tag_q.row_number;
  assign col_number_o  = out_tag_q.col_number;
  assign point_value_o = out_val_q;
  assign kind_o        = out_tag_q.kind;
  assign found_o       = out_tag_q.found;
  assign last_result_o = out_tag_q.last_result;

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !out_push)
    else $error("result register overwritten while stalled");

  // A held result never survives into the load phase
  a_pend_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q != ST_LOAD))
    else $error("pending result outside search");

  // Read data only returns while a scan is running
  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_ROW || state_q == ST_COL))
    else $error("memory read outside scan");

  // Closing a matrix always delivers a result marked final
  a_final_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL && out_free) |=> (out_vld_q && out_tag_q.last_result))
    else $error("final result not marked last");

endmodule
`default_nettype wire
